>>> src/carf_pkg.sv
// ----------------------------------------------------------------------------
// carf_pkg
// Shared types and codes of the clipped alpha rectangle fill engine: the item
// layouts of both channels, the clip window and the command and register codes.
// ----------------------------------------------------------------------------
package carf_pkg;

    // Command codes carried by an input item.
    localparam logic [1:0] CMD_FILL    = 2'd0;
    localparam logic [1:0] CMD_OUTLINE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
    localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
    localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
    localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

    // Blend constants.
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0]  PIXEL_ALPHA  = 8'hFF;

    // One input item.
    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] corner_ax;
        logic signed [15:0] corner_ay;
        logic signed [15:0] corner_bx;
        logic signed [15:0] corner_by;
        logic [23:0]        colour;
        logic [7:0]         opacity;
    } carf_in_t;

    // One result item.
    typedef struct packed {
        logic [31:0] pixel_value;
        logic        pixel_in_range;
    } carf_out_t;

    // Clip window, ordered and clamped to the screen.
    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
    } carf_win_t;

endpackage

>>> src/carf_ifs.sv
// ----------------------------------------------------------------------------
// carf_ifs
// Valid/ready channels of the fill engine: command items in, result items out.
// ----------------------------------------------------------------------------
interface carf_in_if;
    logic               valid;
    logic               ready;
    carf_pkg::carf_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface carf_out_if;
    logic                valid;
    logic                ready;
    carf_pkg::carf_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/carf_clip.sv
// ----------------------------------------------------------------------------
// carf_clip
// Clip corner registers and the registered clip window derived from them.
// ----------------------------------------------------------------------------
module carf_clip #(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output carf_pkg::carf_win_t win
);

    localparam logic signed [15:0] XMAX = 16'(SCREEN_WIDTH - 1);
    localparam logic signed [15:0] YMAX = 16'(SCREEN_HEIGHT - 1);

    logic signed [15:0]  left_reg, top_reg, right_reg, bottom_reg;
    logic signed [15:0]  xlo, xhi, ylo, yhi;
    carf_pkg::carf_win_t win_next;
    carf_pkg::carf_win_t win_reg;

    // Corner registers, written by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                carf_pkg::REG_CLIP_LEFT:   left_reg   <= cfg_data;
                carf_pkg::REG_CLIP_TOP:    top_reg    <= cfg_data;
                carf_pkg::REG_CLIP_RIGHT:  right_reg  <= cfg_data;
                carf_pkg::REG_CLIP_BOTTOM: bottom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Order each corner pair and clamp it to the screen; all-zero corners select the whole screen.
    always_comb
    begin
        xlo = (left_reg < right_reg) ? left_reg : right_reg;
        xhi = (left_reg < right_reg) ? right_reg : left_reg;
        ylo = (top_reg < bottom_reg) ? top_reg : bottom_reg;
        yhi = (top_reg < bottom_reg) ? bottom_reg : top_reg;
        if (left_reg == '0 && top_reg == '0 && right_reg == '0 && bottom_reg == '0)
        begin
            win_next.x0 = '0;
            win_next.y0 = '0;
            win_next.x1 = XMAX;
            win_next.y1 = YMAX;
        end
        else
        begin
            win_next.x0 = xlo[15] ? 16'sd0 : xlo;
            win_next.y0 = ylo[15] ? 16'sd0 : ylo;
            win_next.x1 = (xhi > XMAX) ? XMAX : xhi;
            win_next.y1 = (yhi > YMAX) ? YMAX : yhi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.x0 <= '0;
            win_reg.y0 <= '0;
            win_reg.x1 <= XMAX;
            win_reg.y1 <= YMAX;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    assign win = win_reg;

endmodule

>>> src/carf_blend.sv
// ----------------------------------------------------------------------------
// carf_blend
// Shared pixel blend unit: mixes an RGB colour into a stored ARGB pixel and
// registers the result for the write back.
// ----------------------------------------------------------------------------
module carf_blend (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] dst,
    input  logic [23:0] src,
    input  logic [7:0]  alpha,
    output logic [31:0] mix
);

    logic [31:0] mix_next;
    logic [31:0] mix_reg;

    // One channel: (c*a + d*(255-a)) >> 8, low eight bits kept.
    function automatic logic [7:0] mix_chan(input logic [7:0] c, input logic [7:0] d,
                                            input logic [7:0] a);
        logic [15:0] sum;
        sum = 16'(c) * 16'(a) + 16'(d) * 16'(8'hFF - a);
        return sum[15:8];
    endfunction

    always_comb
    begin
        if (alpha == carf_pkg::ALPHA_OPAQUE)
        begin
            mix_next = {carf_pkg::PIXEL_ALPHA, src};
        end
        else if (alpha == carf_pkg::ALPHA_CLEAR)
        begin
            mix_next = dst;
        end
        else
        begin
            mix_next = {carf_pkg::PIXEL_ALPHA,
                        mix_chan(src[23:16], dst[23:16], alpha),
                        mix_chan(src[15:8],  dst[15:8],  alpha),
                        mix_chan(src[7:0],   dst[7:0],   alpha)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mix_reg <= mix_next;
        end
    end

    assign mix = mix_reg;

endmodule

>>> src/carf_store.sv
// ----------------------------------------------------------------------------
// carf_store
// Single-port frame store with registered read data and a clearing pass that
// zeroes every pixel after reset, one word per cycle.
// ----------------------------------------------------------------------------
module carf_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata,
    output logic          busy
);

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rdata_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          busy_reg;

    // Clearing pass sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (clr_cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Memory array: clear writes take priority while the pass runs.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (we)
        begin
            mem[addr] <= wdata;
        end
        if (rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

>>> src/clipped_alpha_rect_fill_top.sv
// ----------------------------------------------------------------------------
// clipped_alpha_rect_fill_top
// Rectangle fill, outline and pixel read engine over an ARGB frame store.
// ----------------------------------------------------------------------------
// After reset the frame store is zeroed by a clearing pass over every pixel,
// during which no item is accepted (clip registers can be written). The
// engine then handles one item at a time. Every span (one for a fill, four
// for an outline) starts with a setup state; each covered pixel is then
// written directly when opaque (opacity 255 and all outlines), or read, blended
// and written back in turn on the single frame store port when blended. A fill
// with opacity 0 or an unused command goes straight to the result state; a read
// issues a store read when the pixel is in range and waits for its data. The result
// item is held in an output register, so the next item is taken while it waits.
// ----------------------------------------------------------------------------
module clipped_alpha_rect_fill_top #(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    carf_in_if.sink           item_in,
    carf_out_if.source        item_out,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    localparam int XW    = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int YW    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPAN,
        S_PIX_RD,
        S_PIX_MIX,
        S_PIX_WR,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_RESULT
    } state_t;

    state_t              state_reg, state_next;
    carf_pkg::carf_in_t  item_reg, item_next;
    logic [7:0]          alpha_reg, alpha_next;
    logic [1:0]          span_reg, span_next;
    logic [1:0]          last_span_reg, last_span_next;
    logic [XW-1:0]       x_reg, x_next, x_lo_reg, x_lo_next, x_hi_reg, x_hi_next;
    logic [YW-1:0]       y_reg, y_next, y_hi_reg, y_hi_next;
    logic [31:0]         res_value_reg, res_value_next;
    logic                res_range_reg, res_range_next;
    logic                out_valid_reg, out_valid_next;
    carf_pkg::carf_out_t out_data_reg, out_data_next;

    carf_pkg::carf_win_t win;
    logic                clr_busy;
    logic                accept;
    logic                opaque;
    logic                span_last_pix;
    logic [AW-1:0]       row_base, pix_addr;
    logic                mem_rd, mem_we;
    logic [31:0]         mem_wdata, mem_rdata, mix_out;

    logic signed [15:0]  px, qx, py, qy;
    logic signed [15:0]  lo_x, hi_x, lo_y, hi_y;
    logic                span_empty;

    // Clip registers and window.
    carf_clip #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .win       (win)
    );

    // Frame store.
    carf_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (mem_rd),
        .we    (mem_we),
        .addr  (pix_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata),
        .busy  (clr_busy)
    );

    // Shared blend unit.
    carf_blend u_blend (
        .clk   (clk),
        .en    (state_reg == S_PIX_MIX),
        .dst   (mem_rdata),
        .src   (item_reg.colour),
        .alpha (alpha_reg),
        .mix   (mix_out)
    );

    assign item_in.ready  = (state_reg == S_IDLE) && !clr_busy;
    assign accept         = item_in.valid && item_in.ready;
    assign item_out.valid = out_valid_reg;
    assign item_out.data  = out_data_reg;

    assign opaque        = (alpha_reg == carf_pkg::ALPHA_OPAQUE);
    assign span_last_pix = (x_reg == x_hi_reg) && (y_reg == y_hi_reg);
    assign row_base      = AW'(y_reg) * AW'(SCREEN_WIDTH);
    assign pix_addr      = row_base + AW'(x_reg);

    // Span corners: the whole box for a fill, one edge per span for an outline.
    always_comb
    begin
        if (item_reg.command == carf_pkg::CMD_FILL)
        begin
            px = item_reg.corner_ax;
            qx = item_reg.corner_bx;
            py = item_reg.corner_ay;
            qy = item_reg.corner_by;
        end
        else
        begin
            case (span_reg)
                2'd0:
                begin
                    px = item_reg.corner_ax;
                    qx = item_reg.corner_bx;
                    py = item_reg.corner_ay;
                    qy = item_reg.corner_ay;
                end
                2'd1:
                begin
                    px = item_reg.corner_ax;
                    qx = item_reg.corner_bx;
                    py = item_reg.corner_by;
                    qy = item_reg.corner_by;
                end
                2'd2:
                begin
                    px = item_reg.corner_ax;
                    qx = item_reg.corner_ax;
                    py = item_reg.corner_ay;
                    qy = item_reg.corner_by;
                end
                default:
                begin
                    px = item_reg.corner_bx;
                    qx = item_reg.corner_bx;
                    py = item_reg.corner_ay;
                    qy = item_reg.corner_by;
                end
            endcase
        end
    end

    // Order the span corners and clamp them to the clip window.
    always_comb
    begin
        lo_x = (px < qx) ? px : qx;
        hi_x = (px < qx) ? qx : px;
        lo_y = (py < qy) ? py : qy;
        hi_y = (py < qy) ? qy : py;
        if (lo_x < win.x0)
        begin
            lo_x = win.x0;
        end
        if (hi_x > win.x1)
        begin
            hi_x = win.x1;
        end
        if (lo_y < win.y0)
        begin
            lo_y = win.y0;
        end
        if (hi_y > win.y1)
        begin
            hi_y = win.y1;
        end
        span_empty = (lo_x > hi_x) || (lo_y > hi_y);
    end

    // Frame store port control.
    always_comb
    begin
        mem_rd    = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = mix_out;
        case (state_reg)
            S_PIX_RD:
            begin
                mem_we    = opaque;
                mem_rd    = !opaque;
                mem_wdata = {carf_pkg::PIXEL_ALPHA, item_reg.colour};
            end
            S_PIX_WR:   mem_we = 1'b1;
            S_RD_ISSUE: mem_rd = res_range_reg;
            default: ;
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        alpha_next     = alpha_reg;
        span_next      = span_reg;
        last_span_next = last_span_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        x_lo_next      = x_lo_reg;
        x_hi_next      = x_hi_reg;
        y_hi_next      = y_hi_reg;
        res_value_next = res_value_reg;
        res_range_next = res_range_reg;
        out_valid_next = out_valid_reg && !item_out.ready;
        out_data_next  = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next      = item_in.data;
                    span_next      = 2'd0;
                    res_value_next = '0;
                    res_range_next = 1'b0;
                    x_next         = item_in.data.corner_ax[XW-1:0];
                    y_next         = item_in.data.corner_ay[YW-1:0];
                    case (item_in.data.command)
                        carf_pkg::CMD_FILL:
                        begin
                            alpha_next     = item_in.data.opacity;
                            last_span_next = 2'd0;
                            if (item_in.data.opacity == carf_pkg::ALPHA_CLEAR)
                            begin
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_SPAN;
                            end
                        end
                        carf_pkg::CMD_OUTLINE:
                        begin
                            alpha_next     = carf_pkg::ALPHA_OPAQUE;
                            last_span_next = 2'd3;
                            state_next     = S_SPAN;
                        end
                        carf_pkg::CMD_READ:
                        begin
                            res_range_next = !item_in.data.corner_ax[15]
                                && !item_in.data.corner_ay[15]
                                && ({1'b0, item_in.data.corner_ax} < 17'(SCREEN_WIDTH))
                                && ({1'b0, item_in.data.corner_ay} < 17'(SCREEN_HEIGHT));
                            state_next     = S_RD_ISSUE;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            S_SPAN:
            begin
                if (span_empty)
                begin
                    if (span_reg == last_span_reg)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        span_next = span_reg + 1'b1;
                    end
                end
                else
                begin
                    x_lo_next  = lo_x[XW-1:0];
                    x_hi_next  = hi_x[XW-1:0];
                    y_hi_next  = hi_y[YW-1:0];
                    x_next     = lo_x[XW-1:0];
                    y_next     = lo_y[YW-1:0];
                    state_next = S_PIX_RD;
                end
            end

            S_PIX_RD, S_PIX_WR:
            begin
                if (state_reg == S_PIX_RD && !opaque)
                begin
                    state_next = S_PIX_MIX;
                end
                else if (span_last_pix)
                begin
                    if (span_reg == last_span_reg)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        span_next  = span_reg + 1'b1;
                        state_next = S_SPAN;
                    end
                end
                else
                begin
                    state_next = S_PIX_RD;
                    if (x_reg == x_hi_reg)
                    begin
                        x_next = x_lo_reg;
                        y_next = y_reg + 1'b1;
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;
                    end
                end
            end

            S_PIX_MIX:
            begin
                state_next = S_PIX_WR;
            end

            S_RD_ISSUE:
            begin
                state_next = S_RD_WAIT;
            end

            S_RD_WAIT:
            begin
                res_value_next = res_range_reg ? mem_rdata : 32'd0;
                state_next     = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || item_out.ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.pixel_value    = res_value_reg;
                    out_data_next.pixel_in_range = res_range_reg;
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer registers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            alpha_reg     <= '0;
            span_reg      <= '0;
            last_span_reg <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            x_lo_reg      <= '0;
            x_hi_reg      <= '0;
            y_hi_reg      <= '0;
            res_value_reg <= '0;
            res_range_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            alpha_reg     <= alpha_next;
            span_reg      <= span_next;
            last_span_reg <= last_span_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            x_lo_reg      <= x_lo_next;
            x_hi_reg      <= x_hi_next;
            y_hi_reg      <= y_hi_next;
            res_value_reg <= res_value_next;
            res_range_reg <= res_range_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Pixel writes only come from the pixel states, and always land in the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == S_PIX_RD || state_reg == S_PIX_WR)
                    && ({1'b0, pix_addr} < (AW + 1)'(DEPTH))))
        else $error("frame store write outside a pixel state or beyond the screen");

    // The pixel walk stays inside the span that was set up.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PIX_RD) |-> (x_reg >= x_lo_reg && x_reg <= x_hi_reg
                                     && y_reg <= y_hi_reg))
        else $error("pixel counters left the current span");

    // A blend always follows a read of the same pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PIX_MIX) |-> ($past(state_reg == S_PIX_RD) && $stable(pix_addr)))
        else $error("blend stage without a preceding pixel read");

    // A new result only appears out of the result state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result item raised outside the result state");

    // No item is taken while the clearing pass runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> (state_reg == S_IDLE && !out_valid_reg))
        else $error("engine active during the clearing pass");

endmodule
